FILE: sv/bam_pkg.sv
// Package for the bitap approximate matcher: sizes, register indexes and vector helpers.
package bam_pkg;

    localparam int unsigned MAX_PATTERN = 32;
    localparam int unsigned MAX_ERRORS  = 7;
    localparam int unsigned NUM_LEVELS  = MAX_ERRORS + 1;
    localparam int unsigned PAT_WORDS   = MAX_PATTERN / 8;

    localparam int unsigned LEN_W    = 6;
    localparam int unsigned ERR_W    = 3;
    localparam int unsigned POS_W    = $clog2(MAX_PATTERN);
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 40;

    typedef logic [MAX_PATTERN-1:0] vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_WORD_0 = 3'd0,
        CFG_PATTERN_WORD_1 = 3'd1,
        CFG_PATTERN_WORD_2 = 3'd2,
        CFG_PATTERN_WORD_3 = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4,
        CFG_MAX_ERRORS     = 3'd5
    } cfg_index_t;

    // Start value of an error level: all ones with the lowest 'level' bits cleared.
    function automatic vec_t reset_vector(input int unsigned level);
        vec_t ones;
        ones = '1;
        return ones << level;
    endfunction

endpackage

FILE: sv/bitap_approximate_matcher.sv
// Top level of the bitap approximate matcher: pattern registers, vector chain and output buffer.
//
// Usage: pattern bytes, pattern length and the accepted edit distance are written through the
// cfg_* channel (index 0..3 pattern words, 4 length, 5 error limit) while no text is in flight.
// Text arrives one byte per request on the s_* channel; s_tuser marks the first byte of a
// buffer, which restarts the error vectors and the offset count. Every byte yields exactly
// one result request on the m_* channel: a match flag and the byte's offset in its buffer.
// A byte's result is registered in the main register, or in the skid register while a result waits.
// Throughput is one byte per cycle while s_tready is high, as the error-vector chain is updated
// combinationally (the comparison with all pattern bytes and eight levels of shift-and logic).
// A two-entry output buffer (main register plus skid register) lets the block take one more
// byte while a result waits; s_tready drops only once both entries are full, and rises again
// as soon as the receiver takes a result. Nothing is lost or repeated under stalls.
// Reset (aresetn low, synchronous) empties the output buffer, sets the vectors and offset to
// their start values, clears the pattern, sets the length to one and the error limit to zero.
module bitap_approximate_matcher (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bam_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bam_pkg::CFG_DATA_W-1:0]        cfg_data,
    // text input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bam_pkg::S_DATA_W-1:0]          s_tdata,   // [7:0] text_byte
    input  logic                                  s_tuser,   // [0] first_of_buffer
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bam_pkg::M_DATA_W-1:0]          m_tdata    // [0] match_found,
                                                             // [32:1] end_offset, [39:33] zero
);

    logic [bam_pkg::CFG_DATA_W-1:0]  pattern_word_reg [bam_pkg::PAT_WORDS];
    logic [bam_pkg::LEN_W-1:0]       pattern_length_reg;
    logic [bam_pkg::ERR_W-1:0]       max_errors_reg;

    bam_pkg::vec_t                   vec_reg  [bam_pkg::NUM_LEVELS];
    bam_pkg::vec_t                   vec_next [bam_pkg::NUM_LEVELS];
    bam_pkg::vec_t                   vec_base [bam_pkg::NUM_LEVELS];
    logic [bam_pkg::OFFSET_W-1:0]    offset_reg;
    logic [bam_pkg::OFFSET_W-1:0]    offset_cur;

    bam_pkg::vec_t                   mismatch;
    bam_pkg::vec_t                   sel_vec;
    logic [bam_pkg::POS_W-1:0]       hit_pos;
    logic                            hit;

    logic                            main_valid_reg, main_valid_next;
    logic                            skid_valid_reg, skid_valid_next;
    logic                            main_match_reg, main_match_next;
    logic [bam_pkg::OFFSET_W-1:0]    main_offset_reg, main_offset_next;
    logic                            skid_match_reg;
    logic [bam_pkg::OFFSET_W-1:0]    skid_offset_reg;

    logic                            s_accept;
    logic                            m_accept;
    logic                            cfg_accept;
    logic [bam_pkg::S_DATA_W-1:0]    text_byte;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign m_accept   = m_tvalid && m_tready;
    assign text_byte  = s_tdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < bam_pkg::PAT_WORDS; w++) begin
                pattern_word_reg[w] <= '0;
            end
            pattern_length_reg <= bam_pkg::LEN_W'(1);
            max_errors_reg     <= '0;
        end else if (cfg_accept) begin
            unique case (cfg_index) inside
                bam_pkg::CFG_PATTERN_WORD_0,
                bam_pkg::CFG_PATTERN_WORD_1,
                bam_pkg::CFG_PATTERN_WORD_2,
                bam_pkg::CFG_PATTERN_WORD_3: begin
                    pattern_word_reg[cfg_index[$clog2(bam_pkg::PAT_WORDS)-1:0]] <= cfg_data;
                end
                bam_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_data[bam_pkg::LEN_W-1:0];
                end
                bam_pkg::CFG_MAX_ERRORS: begin
                    max_errors_reg <= cfg_data[bam_pkg::ERR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Mismatch mask: a bit is cleared where an in-use pattern byte equals the text byte.
    always_comb begin
        mismatch = '1;
        for (int i = 0; i < bam_pkg::MAX_PATTERN; i++) begin
            if ((bam_pkg::LEN_W'(i) < pattern_length_reg) &&
                (pattern_word_reg[i / 8][(i % 8) * 8 +: 8] == text_byte)) begin
                mismatch[i] = 1'b0;
            end
        end
    end

    // Vector chain. Each level takes the old value of the level below for substitution and
    // insertion, and its freshly updated value for deletion.
    always_comb begin
        for (int j = 0; j < bam_pkg::NUM_LEVELS; j++) begin
            vec_base[j] = s_tuser ? bam_pkg::reset_vector(j) : vec_reg[j];
        end
        vec_next[0] = (vec_base[0] << 1) | mismatch;
        for (int j = 1; j < bam_pkg::NUM_LEVELS; j++) begin
            vec_next[j] = ((vec_base[j] << 1) | mismatch) & (vec_base[j-1] << 1)
                        & vec_base[j-1] & (vec_next[j-1] << 1);
        end
        offset_cur = s_tuser ? '0 : offset_reg;
    end

    // Match decision on the level given by the error limit.
    always_comb begin
        sel_vec = vec_next[max_errors_reg];
        hit_pos = bam_pkg::POS_W'(pattern_length_reg - bam_pkg::LEN_W'(1));
        if (pattern_length_reg == '0 ||
            pattern_length_reg > bam_pkg::LEN_W'(bam_pkg::MAX_PATTERN)) begin
            hit = 1'b0;
        end else if (bam_pkg::LEN_W'(max_errors_reg) >= pattern_length_reg) begin
            hit = 1'b1;
        end else begin
            hit = !sel_vec[hit_pos];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < bam_pkg::NUM_LEVELS; j++) begin
                vec_reg[j] <= bam_pkg::reset_vector(j);
            end
            offset_reg <= '0;
        end else if (s_accept) begin
            vec_reg    <= vec_next;
            offset_reg <= offset_cur + bam_pkg::OFFSET_W'(1);
        end
    end

    // Output buffer: the main register feeds m_*, the skid register catches one extra result.
    always_comb begin
        main_valid_next  = main_valid_reg;
        skid_valid_next  = skid_valid_reg;
        main_match_next  = main_match_reg;
        main_offset_next = main_offset_reg;
        if (skid_valid_reg) begin
            if (m_accept) begin
                main_match_next  = skid_match_reg;
                main_offset_next = skid_offset_reg;
                skid_valid_next  = 1'b0;
            end
        end else if (s_accept) begin
            if (!main_valid_reg || m_accept) begin
                main_valid_next  = 1'b1;
                main_match_next  = hit;
                main_offset_next = offset_cur;
            end else begin
                skid_valid_next = 1'b1;
            end
        end else if (m_accept) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_match_reg  <= main_match_next;
        main_offset_reg <= main_offset_next;
        if (s_accept && !skid_valid_reg && main_valid_reg && !m_accept) begin
            skid_match_reg  <= hit;
            skid_offset_reg <= offset_cur;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(bam_pkg::M_DATA_W - bam_pkg::OFFSET_W - 1){1'b0}},
                       main_offset_reg, main_match_reg};

    // The skid entry is only ever filled behind a waiting main entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds a result while the main entry is empty");

    // A first byte of a buffer leaves the offset count at one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser |=> offset_reg == bam_pkg::OFFSET_W'(1))
        else $error("offset did not restart at the first byte of a buffer");

    // Level one always has a clear lowest bit, as the substitution and deletion terms shift
    // a zero in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vec_reg[1][0] == 1'b0)
        else $error("error level one has its lowest bit set");

    // A result request the receiver did not take is still there, unchanged, in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

endmodule
